// File: rtl/accb_pkg.sv
// ----------------------------------------------------------------------------
// Angular coverage buffer package
// Shared widths, command codes, controller states and the angle magnitude
// helper used by the coverage buffer and its channel interfaces.
// ----------------------------------------------------------------------------
package accb_pkg;

    // Payload widths of the channels.
    localparam int CMD_W   = 2;
    localparam int ANGLE_W = 16;
    localparam int MAG_W   = ANGLE_W + 1;

    // Coverage map storage is organised as 32-bit words.
    localparam int WORD_W = 32;
    localparam int BIT_W  = 5;

    // Q3.12 angle times Q8.16 multiplier leaves 28 fraction bits.
    localparam int FRAC_W = 28;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_TEST  = 2'd1,
        CMD_MARK  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_BIN,
        S_ARC,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

    // Magnitude of a two's complement angle; the most negative code gives 2^15.
    function automatic logic [MAG_W-1:0] angle_mag(input logic [ANGLE_W-1:0] a);
        logic [MAG_W-1:0] ext;
        ext = {1'b0, a};
        return a[ANGLE_W-1] ? ((MAG_W'(1) << ANGLE_W) - ext) : ext;
    endfunction

endpackage

// File: rtl/accb_cmd_if.sv
// ----------------------------------------------------------------------------
// Command channel interface
// Valid/ready channel that carries one command and its two arc angles.
// ----------------------------------------------------------------------------
interface accb_cmd_if import accb_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          cmd;
    logic signed [ANGLE_W-1:0] angle_start;
    logic signed [ANGLE_W-1:0] angle_end;

    modport source (output valid, cmd, angle_start, angle_end, input ready);
    modport sink   (input valid, cmd, angle_start, angle_end, output ready);
endinterface

// File: rtl/accb_res_if.sv
// ----------------------------------------------------------------------------
// Result channel interface
// Valid/ready channel that carries the two status flags of one command.
// ----------------------------------------------------------------------------
interface accb_res_if import accb_pkg::*; ();
    logic valid;
    logic ready;
    logic range_open;
    logic all_covered;

    modport source (output valid, range_open, all_covered, input ready);
    modport sink   (input valid, range_open, all_covered, output ready);
endinterface

// File: rtl/angular_clip_coverage_buffer.sv
// ----------------------------------------------------------------------------
// Angular clip coverage buffer
// Circular one-bit coverage map over a full turn with clear, test and mark.
// ----------------------------------------------------------------------------
// Usage: commands arrive on i_cmd and each produces exactly one transfer on
// o_res. A clear empties the map, a test reports whether any bin of the arc
// between the two angles is still open, and a mark covers every bin of that
// arc. Each result also says whether the whole map is covered.
// A test or mark turns the angles into bins, finds the arc bounds and then
// walks the 32-bit map words the arc touches, one read-modify-write per word
// over the single map RAM; for 1280 bins the arc touches at most 21 words.
// A clear writes zeros to every map word (BINS/32 rounded up).
// After reset the block sweeps zeros through every map word, one word a
// cycle, and holds i_cmd.ready low until done.
// The result sits in an output register: a new command is taken while it
// waits, and a finished command only stalls in its last step when the
// receiver has not yet taken the previous result.
// ----------------------------------------------------------------------------
module angular_clip_coverage_buffer import accb_pkg::*; #(
    parameter int BINS = 1280
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    accb_cmd_if.sink     i_cmd,
    accb_res_if.source   o_res
);
    // Map geometry.
    localparam int NWORDS = (BINS + WORD_W - 1) / WORD_W;
    localparam int ADDR_W = $clog2(NWORDS);
    localparam int BIN_W  = $clog2(BINS);
    localparam int CNT_W  = $clog2(BINS + 1);

    // BINS/(2*pi) as unsigned Q8.16, rounded to nearest.
    localparam logic [63:0] BIN_MULT_64 =
        (64'(BINS) * 64'd10430378350 + 64'd500000) / 64'd1000000;
    localparam int MULT_W = $clog2(BIN_MULT_64 + 64'd1);
    localparam logic [MULT_W-1:0] BIN_MULT = BIN_MULT_64[MULT_W-1:0];
    localparam int PROD_W = MAG_W + MULT_W;

    localparam logic [BIN_W:0]      BINS_X    = (BIN_W + 1)'(BINS);
    localparam logic [BIN_W:0]      HALF_X    = (BIN_W + 1)'(BINS / 2);
    localparam logic [CNT_W-1:0]    BINS_CNT  = CNT_W'(BINS);
    localparam logic [ADDR_W-1:0]   LAST_ADDR = ADDR_W'(NWORDS - 1);
    localparam logic [BIT_W-1:0]    TOP_BIT   = BIT_W'((BINS - 1) % WORD_W);
    localparam logic [BIT_W-1:0]    WORD_TOP  = BIT_W'(WORD_W - 1);

    // The scaled angle stays below twice BINS, so one conditional subtract
    // wraps it. A negative angle is then reflected back into range.
    function automatic logic [BIN_W-1:0] wrap_bin(input logic [BIN_W:0] raw,
                                                  input logic neg);
        logic [BIN_W:0] red;
        red = (raw >= BINS_X) ? (raw - BINS_X) : raw;
        if (neg && (red != '0)) begin
            red = BINS_X - red;
        end
        return red[BIN_W-1:0];
    endfunction

    // Bits lo to hi inclusive of one map word.
    function automatic logic [WORD_W-1:0] range_mask(input logic [BIT_W-1:0] lo,
                                                     input logic [BIT_W-1:0] hi);
        logic [WORD_W-1:0] ones;
        ones = '1;
        return (ones << lo) & (ones >> (WORD_TOP - hi));
    endfunction

    // Controller state and command flags.
    t_state            r_state;
    t_state            n_state;
    logic              r_clr_cmd;
    logic              r_test;
    logic              r_mark;
    logic              r_open;

    // Angle to bin pipeline.
    logic [PROD_W-1:0] n_prod_s;
    logic [PROD_W-1:0] n_prod_e;
    logic [PROD_W-1:0] r_prod_s;
    logic [PROD_W-1:0] r_prod_e;
    logic              r_neg_s;
    logic              r_neg_e;
    logic [BIN_W-1:0]  r_bin_s;
    logic [BIN_W-1:0]  r_bin_e;

    // Arc bounds.
    logic [BIN_W:0]    n_fwd_raw;
    logic [BIN_W:0]    n_fwd;
    logic [BIN_W-1:0]  n_first;
    logic [BIN_W-1:0]  n_last;
    logic [BIT_W-1:0]  r_first_bit;
    logic [BIT_W-1:0]  r_last_bit;
    logic [ADDR_W-1:0] r_last_word;

    // Word walk and read-modify-write.
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] n_addr_inc;
    logic              r_first_flag;
    logic              r_rd_pend;
    logic [ADDR_W-1:0] r_rd_addr;
    logic              r_rd_first;
    logic              r_rd_last;
    logic              issue_last;
    logic [BIT_W-1:0]  rmw_lo;
    logic [BIT_W-1:0]  rmw_hi;
    logic [WORD_W-1:0] rmw_mask;
    logic [WORD_W-1:0] rmw_new;
    logic              rmw_we;

    // Count of covered bins.
    logic [CNT_W-1:0]  r_count;

    // RAM ports.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;

    // Control strobes.
    logic              in_ready;
    logic              clr_we;
    logic              issue;
    logic              out_free;
    logic              load_out;
    logic              in_accept;

    // Output register.
    logic              r_out_valid;
    logic              r_out_open;
    logic              r_out_full;

    accb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NWORDS)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Datapath combinational logic
    // ------------------------------------------------------------------
    assign n_prod_s = angle_mag(i_cmd.angle_start) * BIN_MULT;
    assign n_prod_e = angle_mag(i_cmd.angle_end) * BIN_MULT;

    // The arc is the shorter way round; it starts at whichever bin lies
    // behind the other.
    assign n_fwd_raw = {1'b0, r_bin_e} + BINS_X - {1'b0, r_bin_s};
    assign n_fwd     = (n_fwd_raw >= BINS_X) ? (n_fwd_raw - BINS_X) : n_fwd_raw;
    assign n_first   = (n_fwd < HALF_X) ? r_bin_s : r_bin_e;
    assign n_last    = (n_fwd < HALF_X) ? r_bin_e : r_bin_s;

    assign n_addr_inc = (r_addr == LAST_ADDR) ? '0 : (r_addr + ADDR_W'(1));
    assign issue_last = (r_addr == r_last_word);

    // The final map word may be only partly populated.
    assign rmw_lo   = r_rd_first ? r_first_bit : '0;
    assign rmw_hi   = r_rd_last ? r_last_bit :
                      ((r_rd_addr == LAST_ADDR) ? TOP_BIT : WORD_TOP);
    assign rmw_mask = range_mask(rmw_lo, rmw_hi);
    assign rmw_new  = rmw_mask & ~ram_rdata;
    assign rmw_we   = r_rd_pend && r_mark;

    assign ram_we    = clr_we || rmw_we;
    assign ram_waddr = clr_we ? r_addr : r_rd_addr;
    assign ram_wdata = clr_we ? '0 : (ram_rdata | rmw_mask);

    assign out_free  = !r_out_valid || o_res.ready;
    assign in_accept = i_cmd.valid && in_ready;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_addr == LAST_ADDR) begin
                    n_state = r_clr_cmd ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd.valid) begin
                    case (i_cmd.cmd)
                        CMD_CLEAR: n_state = S_CLEAR;
                        CMD_TEST:  n_state = S_BIN;
                        CMD_MARK:  n_state = S_BIN;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_BIN:   n_state = S_ARC;
            S_ARC:   n_state = S_RUN;
            S_RUN: begin
                if (issue_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Control outputs
    // ------------------------------------------------------------------
    always_comb begin
        in_ready = 1'b0;
        clr_we   = 1'b0;
        issue    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            S_CLEAR: clr_we   = 1'b1;
            S_IDLE:  in_ready = 1'b1;
            S_RUN:   issue    = 1'b1;
            S_DONE:  load_out = out_free;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_clr_cmd   <= 1'b0;
            r_count     <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            r_test      <= 1'b0;
            r_mark      <= 1'b0;
            r_open      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= issue;

            if (in_accept) begin
                r_open    <= 1'b0;
                r_test    <= (i_cmd.cmd == CMD_TEST);
                r_mark    <= (i_cmd.cmd == CMD_MARK);
                r_clr_cmd <= 1'b1;
                if (i_cmd.cmd == CMD_CLEAR) begin
                    r_addr  <= '0;
                    r_count <= '0;
                end
            end else if (clr_we || issue) begin
                r_addr <= n_addr_inc;
            end else if (r_state == S_ARC) begin
                r_addr <= ADDR_W'(n_first[BIN_W-1:BIT_W]);
            end

            if (r_rd_pend) begin
                if (r_test && (rmw_new != '0)) begin
                    r_open <= 1'b1;
                end
                if (r_mark) begin
                    r_count <= r_count + CNT_W'($countones(rmw_new));
                end
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_prod_s <= n_prod_s;
            r_prod_e <= n_prod_e;
            r_neg_s  <= i_cmd.angle_start[ANGLE_W-1];
            r_neg_e  <= i_cmd.angle_end[ANGLE_W-1];
        end
        if (r_state == S_BIN) begin
            r_bin_s <= wrap_bin(r_prod_s[FRAC_W +: BIN_W + 1], r_neg_s);
            r_bin_e <= wrap_bin(r_prod_e[FRAC_W +: BIN_W + 1], r_neg_e);
        end
        if (r_state == S_ARC) begin
            r_first_bit  <= n_first[BIT_W-1:0];
            r_last_bit   <= n_last[BIT_W-1:0];
            r_last_word  <= ADDR_W'(n_last[BIN_W-1:BIT_W]);
            r_first_flag <= 1'b1;
        end else if (issue) begin
            r_first_flag <= 1'b0;
        end
        if (issue) begin
            r_rd_addr  <= r_addr;
            r_rd_first <= r_first_flag;
            r_rd_last  <= issue_last;
        end
        if (load_out) begin
            r_out_open <= r_open;
            r_out_full <= (r_count == BINS_CNT);
        end
    end

    assign i_cmd.ready       = in_ready;
    assign o_res.valid       = r_out_valid;
    assign o_res.range_open  = r_out_open;
    assign o_res.all_covered = r_out_full;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    // The covered count can never pass the number of bins.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= BINS_CNT)
        else $error("covered bin count exceeds map size");

    // A clear command empties the count at once.
    a_clear_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_cmd.cmd == CMD_CLEAR)) |=> (r_count == '0))
        else $error("count not zero after clear");

    // The map is never written while the block waits for a command.
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((r_state == S_IDLE) && ram_we))
        else $error("map write while idle");

    // Read data is only expected right after a word read was issued.
    a_read_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> ($past(r_state) == S_RUN))
        else $error("read data pending without an issued read");

    // A result is only loaded into a free output register.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (!r_out_valid || o_res.ready))
        else $error("result overwrites an untaken result");
`endif

endmodule

// File: rtl/accb_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module accb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 40
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: verif/tb_angular_clip_coverage_buffer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the angular clip coverage buffer
// Drives clear, test and mark commands into the block and keeps its own copy
// of the coverage map. Each result transfer is checked against the flags that
// this copy gives. The commands are a directed opening, then random sweeps
// round the turn, scattered arcs and odd single commands. Both channels idle at
// random, and the receiver holds off for long spells so that the block stalls.
// ----------------------------------------------------------------------------
module tb_angular_clip_coverage_buffer;
    import accb_pkg::*;

    localparam int MAP_BINS  = 1280;
    localparam int HALF_BINS = MAP_BINS / 2;
    // BINS/(2*pi) as an unsigned Q8.16 constant, rounded to nearest.
    localparam logic [63:0] BIN_MULT =
        (64'(MAP_BINS) * 64'd10430378350 + 64'd500000) / 64'd1000000;

    // One command as it travels on the command channel.
    typedef struct packed {
        t_cmd               op;
        logic [ANGLE_W-1:0] a_start;
        logic [ANGLE_W-1:0] a_end;
    } t_arc_cmd;

    // The two status flags of one result transfer.
    typedef struct packed {
        logic range_open;
        logic all_covered;
    } t_flags;

    logic i_clk = 1'b0;
    logic i_rst_n;

    accb_cmd_if cmd_ch ();
    accb_res_if res_ch ();

    angular_clip_coverage_buffer #(
        .BINS (MAP_BINS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    // The clock runs at 100 MHz.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Commands waiting to be offered, and the flags still owed by the block.
    t_arc_cmd cmd_backlog [$];
    t_flags   flags_due [$];

    // The testbench's own copy of the coverage map.
    logic [MAP_BINS-1:0] cov_map = '0;

    int       n_items    = 0;
    int       n_cmd_acc  = 0;
    int       n_res      = 0;
    int       n_errors   = 0;
    logic     cmd_taken  = 1'b0;
    logic     calm       = 1'b0;
    int       hold_left  = 0;
    int       holds_used = 0;
    t_arc_cmd drive_cmd;
    t_arc_cmd seen_cmd;
    t_flags   want;

    task automatic report_error(input string what);
        $display("%0t ns: %s", $time, what);
        n_errors++;
    endtask

    // Angle to bin index. The Q3.12 magnitude is scaled by the Q8.16
    // multiplier, the 28 fraction bits are dropped (so the value is truncated
    // towards zero), the result is folded into the map and the sign is then
    // applied by counting back from the top of the map.
    function automatic int unsigned angle_bin(input logic [ANGLE_W-1:0] a);
        logic [MAG_W-1:0] mag;
        logic [63:0]      prod;
        int unsigned      r;
        mag  = a[ANGLE_W-1] ? (17'h10000 - {1'b0, a}) : {1'b0, a};
        prod = 64'(mag) * BIN_MULT;
        r    = int'((prod >> FRAC_W) % 64'(MAP_BINS));
        if (a[ANGLE_W-1] && r != 0) begin
            r = MAP_BINS - r;
        end
        return r;
    endfunction

    // Walk the shorter arc between two bins, both ends included. When the
    // forward distance is half a turn or more, the walk starts at the second
    // bin instead. Returns 1 if any bin was still clear on the way.
    function automatic logic sweep_arc(input int unsigned b0, input int unsigned b1,
                                       input logic do_mark);
        int unsigned fwd;
        int unsigned first;
        int unsigned len;
        int unsigned idx;
        logic        open;
        open = 1'b0;
        fwd  = (b1 + MAP_BINS - b0) % MAP_BINS;
        if (fwd < HALF_BINS) begin
            first = b0;
            len   = fwd + 1;
        end else begin
            first = b1;
            len   = ((b0 + MAP_BINS - b1) % MAP_BINS) + 1;
        end
        for (int unsigned k = 0; k < len; k++) begin
            idx = (first + k) % MAP_BINS;
            if (!cov_map[idx]) begin
                open = 1'b1;
            end
            if (do_mark) begin
                cov_map[idx] = 1'b1;
            end
        end
        return open;
    endfunction

    // Apply one accepted command to the map copy and give the flags it owes.
    function automatic t_flags apply_command(input t_arc_cmd c);
        t_flags      f;
        int unsigned b0;
        int unsigned b1;
        f.range_open = 1'b0;
        b0 = angle_bin(c.a_start);
        b1 = angle_bin(c.a_end);
        case (c.op)
            CMD_CLEAR: cov_map = '0;
            CMD_TEST:  f.range_open = sweep_arc(b0, b1, 1'b0);
            CMD_MARK:  void'(sweep_arc(b0, b1, 1'b1));
            default:   ;
        endcase
        f.all_covered = &cov_map;
        return f;
    endfunction

    function automatic void queue_cmd(input t_cmd op, input logic [ANGLE_W-1:0] a,
                                      input logic [ANGLE_W-1:0] b);
        t_arc_cmd c;
        c.op      = op;
        c.a_start = a;
        c.a_end   = b;
        cmd_backlog.push_back(c);
    endfunction

    // Mostly uniform angles, with the extreme codes and the region around
    // zero drawn more often than chance would give.
    function automatic logic [ANGLE_W-1:0] any_angle();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'hFFFF;
                    default: return 16'h0000;
                endcase
            end
            1:       return 16'($urandom_range(0, 400)) - 16'd200;
            default: return 16'($urandom);
        endcase
    endfunction

    // Second angle of an arc: sometimes the same angle, so the arc is a
    // single bin, sometimes a close neighbour, otherwise anything.
    function automatic logic [ANGLE_W-1:0] partner_angle(input logic [ANGLE_W-1:0] a);
        case ($urandom_range(0, 9))
            0:       return a;
            1:       return a + 16'($urandom_range(0, 60)) - 16'd30;
            default: return any_angle();
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Command driver. A new command is put up at the falling edge once the
    // previous one has been transferred; with a chance of about 30 in a hundred
    // the channel is left idle instead, except during the calm stretch.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && (!cmd_ch.valid || cmd_taken)) begin
            if (cmd_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 30)) begin
                drive_cmd          = cmd_backlog.pop_front();
                cmd_ch.valid       <= 1'b1;
                cmd_ch.cmd         <= drive_cmd.op;
                cmd_ch.angle_start <= drive_cmd.a_start;
                cmd_ch.angle_end   <= drive_cmd.a_end;
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver. Ready drops at random, and stays low for the whole of
    // a hold-off so that the output register fills and the block pushes back
    // on the command channel.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            res_ch.ready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 30);
        end
    end

    // Hold-off counter. Two long spells are started, one early and one late
    // in the run; the sender keeps offering commands throughout.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if ((holds_used == 0 && n_cmd_acc >= 150) ||
                     (holds_used == 1 && n_cmd_acc >= 520)) begin
            hold_left  <= 400;
            holds_used <= holds_used + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Every command transfer updates the map copy and queues the
    // flags it should produce; every result transfer is checked against the
    // oldest queued flags. The calm stretch, with no idling on either side,
    // is also timed from here.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cmd_taken <= cmd_ch.valid && cmd_ch.ready;
            calm      <= (n_cmd_acc >= 300) && (n_cmd_acc < 460);
            if (cmd_ch.valid && cmd_ch.ready) begin
                seen_cmd.op      = t_cmd'(cmd_ch.cmd);
                seen_cmd.a_start = cmd_ch.angle_start;
                seen_cmd.a_end   = cmd_ch.angle_end;
                flags_due.push_back(apply_command(seen_cmd));
                n_cmd_acc <= n_cmd_acc + 1;
            end
            if (res_ch.valid && res_ch.ready) begin
                if (flags_due.size() == 0) begin
                    report_error("result transfer with no command outstanding");
                end else begin
                    want = flags_due.pop_front();
                    if (res_ch.range_open !== want.range_open) begin
                        report_error($sformatf("result %0d: range_open %b, expected %b",
                                               n_res, res_ch.range_open, want.range_open));
                    end
                    if (res_ch.all_covered !== want.all_covered) begin
                        report_error($sformatf("result %0d: all_covered %b, expected %b",
                                               n_res, res_ch.all_covered, want.all_covered));
                    end
                end
                n_res <= n_res + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial begin
        int cur;
        int step;
        int stop_at;
        int roll;

        i_rst_n            = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.cmd         = CMD_CLEAR;
        cmd_ch.angle_start = '0;
        cmd_ch.angle_end   = '0;
        res_ch.ready       = 1'b0;

        // Directed opening. An empty map first, then single-bin arcs, the
        // extreme angle codes, arcs either side of half a turn, an arc given
        // end first and one that wraps through bin zero.
        queue_cmd(CMD_TEST, 16'h0000, 16'h0000);
        queue_cmd(CMD_MARK, 16'h0000, 16'h0000);
        queue_cmd(CMD_TEST, 16'h0000, 16'h0000);
        queue_cmd(CMD_TEST, 16'h8000, 16'h7FFF);
        queue_cmd(CMD_MARK, 16'h7FFF, 16'h8000);
        queue_cmd(CMD_TEST, 16'h7FFF, 16'h7FFF);
        queue_cmd(CMD_TEST, 16'h0000, 16'd12867);
        queue_cmd(CMD_TEST, 16'h0000, 16'd12868);
        queue_cmd(CMD_MARK, -16'sd12868, 16'h0000);
        queue_cmd(CMD_MARK, 16'd3000, 16'd1000);
        queue_cmd(CMD_TEST, -16'sd500, 16'd500);
        // Cover the whole turn with five overlapping arcs, then test and mark
        // on a full map and clear it again, with angles that must be ignored.
        queue_cmd(CMD_CLEAR, 16'h0000, 16'h0000);
        for (int k = 0; k < 5; k++) begin
            queue_cmd(CMD_MARK, 16'(k * 6000), 16'(k * 6000 + 6100));
        end
        queue_cmd(CMD_TEST, 16'd100, 16'd9000);
        queue_cmd(CMD_MARK, 16'hFFFF, 16'h0001);
        queue_cmd(CMD_TEST, 16'h8000, 16'h8000);
        queue_cmd(CMD_CLEAR, 16'hFFFF, 16'h7FFF);
        queue_cmd(CMD_TEST, 16'hFFFF, 16'h0001);

        // Random part, built from three kinds of episode.
        while (cmd_backlog.size() < 700) begin
            roll = $urandom_range(0, 3);
            if (roll == 0 || roll == 1) begin
                // A sweep once round the turn in overlapping marks, now and
                // then leaving a hole, with tests inside ground just marked.
                cur     = -int'($urandom_range(6500, 32768));
                stop_at = cur + 25800;
                if ($urandom_range(0, 9) < 7) begin
                    queue_cmd(CMD_CLEAR, any_angle(), any_angle());
                end
                while (cur < stop_at) begin
                    step = $urandom_range(500, 12000);
                    queue_cmd(CMD_MARK, 16'(cur), 16'(cur + step));
                    if ($urandom_range(0, 9) < 4) begin
                        queue_cmd(CMD_TEST, 16'(cur + step / 4), 16'(cur + step / 2));
                    end
                    if ($urandom_range(0, 9) == 0) begin
                        cur = cur + step + int'($urandom_range(50, 800));
                    end else begin
                        cur = cur + step - int'($urandom_range(0, 300));
                    end
                end
                repeat (3) queue_cmd(CMD_TEST, any_angle(), any_angle());
            end else if (roll == 2) begin
                // Scattered arcs after a clear, enough of them at the top end
                // to cover the map by chance.
                queue_cmd(CMD_CLEAR, any_angle(), any_angle());
                repeat ($urandom_range(5, 40)) begin
                    cur = any_angle();
                    if ($urandom_range(0, 9) < 6) begin
                        queue_cmd(CMD_MARK, 16'(cur), partner_angle(16'(cur)));
                    end else begin
                        queue_cmd(CMD_TEST, 16'(cur), partner_angle(16'(cur)));
                    end
                end
            end else begin
                // A few loose commands of any kind.
                repeat ($urandom_range(1, 8)) begin
                    roll = $urandom_range(0, 19);
                    cur  = any_angle();
                    if (roll == 0) begin
                        queue_cmd(CMD_CLEAR, 16'(cur), any_angle());
                    end else if (roll < 10) begin
                        queue_cmd(CMD_MARK, 16'(cur), partner_angle(16'(cur)));
                    end else begin
                        queue_cmd(CMD_TEST, 16'(cur), partner_angle(16'(cur)));
                    end
                end
            end
        end
        n_items = cmd_backlog.size();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every command to be taken and every result to come back,
        // then give the block time to show any stray result.
        while (n_cmd_acc != n_items || flags_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("tb_angular_clip_coverage_buffer: done, clean");
        end else begin
            $display("tb_angular_clip_coverage_buffer: done, errors");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #3_000_000;
        $display("tb_angular_clip_coverage_buffer: done, errors");
        $finish;
    end

endmodule

// File: sim.f
rtl/accb_pkg.sv
rtl/accb_cmd_if.sv
rtl/accb_res_if.sv
rtl/accb_ram.sv
rtl/angular_clip_coverage_buffer.sv
verif/tb_angular_clip_coverage_buffer.sv
